>>> design/grw_pkg.sv
// grw_pkg: types and constants shared by the grid reachability wave block.
// No dependencies.
`default_nettype none

package grw_pkg;

   localparam int COORD_W = 4;

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   typedef struct packed {
      logic               func;
      logic [COORD_W-1:0] cell_x;
      logic [COORD_W-1:0] cell_y;
      logic               occupied;
      logic [COORD_W-1:0] src_x;
      logic [COORD_W-1:0] src_y;
      logic [COORD_W-1:0] dst_x;
      logic [COORD_W-1:0] dst_y;
   } req_type;

   typedef struct packed {
      logic reachable;
      logic target_blocked;
   } rsp_type;

   // Broadcast from the controller to every cell.
   typedef struct packed {
      logic               wr_en;
      logic [COORD_W-1:0] wr_x;
      logic [COORD_W-1:0] wr_y;
      logic               wr_occ;
      logic               seed;
      logic [COORD_W-1:0] src_x;
      logic [COORD_W-1:0] src_y;
      logic [COORD_W-1:0] dst_x;
      logic [COORD_W-1:0] dst_y;
      logic               step;
   } ctrl_type;

   // Per-cell status, also used for the registered row summaries.
   typedef struct packed {
      logic grew;
      logic hit;
      logic blocked;
   } flags_type;

   typedef enum logic {
      ST_IDLE,
      ST_WAVE
   } state_type;

endpackage

`default_nettype wire

>>> design/grid_reachability_wave.sv
// grid_reachability_wave: top level, controller and the array of cell rows.
// Depends on grw_pkg, grw_row and grw_cell.
//
// Keeps a GRID_SIDE x GRID_SIDE occupancy map (all empty after reset) in an
// array of cells, each cell holding its own occupancy bit and wave bit. A
// write transaction (func = write) updates one cell; writes outside the grid
// are dropped. Each write returns one result transaction with both flags 0,
// registered and shown in the cycle after acceptance. A query transaction
// seeds the wave at the source cell (its own occupancy is ignored) and then
// every empty cell takes the wave from its neighbors once per clock, so the
// front advances one grid step per cycle. Row summaries and a global
// summary are registered, so the controller sees wave growth, target hit and
// target occupancy only through the row and global registers. A query is
// decided when the target is hit, the target is occupied or the wave stops
// growing; an occupied target, a target equal to the source, or a source
// outside the grid are decided at the first check of the global summary.
// One transaction is in work at a time; a new one is accepted while the
// block is idle and the result register is empty or being drained.
`default_nettype none

module grid_reachability_wave
   import grw_pkg::*;
#(
   parameter int GRID_SIDE = 16
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output      logic    req_ready,
   input  wire req_type req_data,
   output      logic    rsp_valid,
   input  wire logic    rsp_ready,
   output      rsp_type rsp_data
);

   localparam logic [1:0] SETTLE_DONE = 2'd2;

   state_type state_ff, state_in;
   logic [1:0] settle_ff, settle_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff, rsp_data_in;
   flags_type  glob_ff, glob_in;

   ctrl_type   ctrl;
   logic       accept, is_query, out_free, eval, done, finish;

   logic [GRID_SIDE-1:0] row_reached [GRID_SIDE];
   flags_type            row_flags   [GRID_SIDE];

   // ---------------- handshake ----------------
   assign out_free = ~rsp_valid_ff | rsp_ready;
   assign accept   = req_valid & req_ready;
   assign is_query = (req_data.func == FUNC_QUERY);

   // Global summaries lag the cells through the row and global registers; wait for the seed to show.
   assign eval   = (state_ff == ST_WAVE) && (settle_ff == SETTLE_DONE);
   assign done   = eval && (glob_ff.blocked || glob_ff.hit || !glob_ff.grew);
   assign finish = done && out_free;

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && is_query) state_in = ST_WAVE;
         end
         ST_WAVE: begin
            if (finish) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------- controller outputs ----------------
   always_comb begin
      req_ready   = 1'b0;
      ctrl        = '0;
      ctrl.wr_x   = req_data.cell_x;
      ctrl.wr_y   = req_data.cell_y;
      ctrl.wr_occ = req_data.occupied;
      ctrl.src_x  = req_data.src_x;
      ctrl.src_y  = req_data.src_y;
      ctrl.dst_x  = req_data.dst_x;
      ctrl.dst_y  = req_data.dst_y;
      case (state_ff)
         ST_IDLE: begin
            req_ready  = out_free;
            ctrl.wr_en = accept && !is_query;
            ctrl.seed  = accept && is_query;
         end
         ST_WAVE: begin
            // extra steps after the decision are harmless: hit, blocked and stopped growth all persist
            ctrl.step = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // ---------------- settle counter and result register ----------------
   always_comb begin
      settle_in = settle_ff;
      if (accept) begin
         settle_in = '0;
      end else if (state_ff == ST_WAVE && settle_ff != SETTLE_DONE) begin
         settle_in = settle_ff + 2'd1;
      end

      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (accept && !is_query) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
      end else if (finish) begin
         rsp_valid_in                = 1'b1;
         rsp_data_in.target_blocked  = glob_ff.blocked;
         rsp_data_in.reachable       = ~glob_ff.blocked & glob_ff.hit;
      end
   end

   // ---------------- global summary of the rows ----------------
   always_comb begin
      glob_in = '0;
      for (int r = 0; r < GRID_SIDE; r++) begin
         glob_in = glob_in | row_flags[r];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         settle_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         glob_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         settle_ff    <= settle_in;
         rsp_valid_ff <= rsp_valid_in;
         glob_ff      <= glob_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------- cell array ----------------
   for (genvar y = 0; y < GRID_SIDE; y++) begin : g_row
      logic [GRID_SIDE-1:0] up_nb, down_nb;
      if (y > 0) begin : g_u
         assign up_nb = row_reached[y-1];
      end else begin : g_u0
         assign up_nb = '0;
      end
      if (y < GRID_SIDE - 1) begin : g_d
         assign down_nb = row_reached[y+1];
      end else begin : g_d0
         assign down_nb = '0;
      end

      grw_row #(
         .GRID_SIDE (GRID_SIDE),
         .ROW       (y)
      ) u_row (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (ctrl),
         .up_reached   (up_nb),
         .down_reached (down_nb),
         .reached      (row_reached[y]),
         .row_flags    (row_flags[y])
      );
   end

endmodule

`default_nettype wire

>>> design/grw_cell.sv
// grw_cell: one grid cell holding its occupancy and wave bits.
// Depends on grw_pkg.
`default_nettype none

module grw_cell
   import grw_pkg::*;
#(
   parameter int CX = 0,
   parameter int CY = 0
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire ctrl_type  ctrl,
   input  wire logic      left_reached,
   input  wire logic      right_reached,
   input  wire logic      up_reached,
   input  wire logic      down_reached,
   output      logic      reached,
   output      flags_type flags
);

   logic occ_ff, occ_in;
   logic reached_ff, reached_in;
   logic grew_ff, grew_in;
   logic is_dst_ff, is_dst_in;
   logic is_src, is_dst, is_wr, nb_any;

   assign is_wr  = ctrl.wr_en && (32'(ctrl.wr_x) == CX) && (32'(ctrl.wr_y) == CY);
   assign is_src = (32'(ctrl.src_x) == CX) && (32'(ctrl.src_y) == CY);
   assign is_dst = (32'(ctrl.dst_x) == CX) && (32'(ctrl.dst_y) == CY);
   assign nb_any = left_reached | right_reached | up_reached | down_reached;

   always_comb begin
      occ_in     = is_wr ? ctrl.wr_occ : occ_ff;
      reached_in = reached_ff;
      grew_in    = 1'b0;
      is_dst_in  = is_dst_ff;
      if (ctrl.seed) begin
         // source seeds the wave whatever its own occupancy
         reached_in = is_src;
         grew_in    = is_src;
         is_dst_in  = is_dst;
      end else if (ctrl.step) begin
         reached_in = reached_ff | (~occ_ff & nb_any);
         grew_in    = reached_in & ~reached_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff     <= 1'b0;
         reached_ff <= 1'b0;
         grew_ff    <= 1'b0;
         is_dst_ff  <= 1'b0;
      end else begin
         occ_ff     <= occ_in;
         reached_ff <= reached_in;
         grew_ff    <= grew_in;
         is_dst_ff  <= is_dst_in;
      end
   end

   assign reached       = reached_ff;
   assign flags.grew    = grew_ff;
   assign flags.hit     = reached_ff & is_dst_ff;
   assign flags.blocked = occ_ff & is_dst_ff;

endmodule

`default_nettype wire

>>> design/grw_row.sv
// grw_row: one row of cells with a registered OR summary of their flags.
// Depends on grw_pkg and grw_cell.
`default_nettype none

module grw_row
   import grw_pkg::*;
#(
   parameter int GRID_SIDE = 16,
   parameter int ROW       = 0
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire ctrl_type             ctrl,
   input  wire logic [GRID_SIDE-1:0] up_reached,
   input  wire logic [GRID_SIDE-1:0] down_reached,
   output      logic [GRID_SIDE-1:0] reached,
   output      flags_type            row_flags
);

   flags_type cell_flags [GRID_SIDE];
   flags_type row_flags_ff, row_flags_in;

   for (genvar x = 0; x < GRID_SIDE; x++) begin : g_cell
      logic left_nb, right_nb;
      if (x > 0) begin : g_l
         assign left_nb = reached[x-1];
      end else begin : g_l0
         assign left_nb = 1'b0;
      end
      if (x < GRID_SIDE - 1) begin : g_r
         assign right_nb = reached[x+1];
      end else begin : g_r0
         assign right_nb = 1'b0;
      end

      grw_cell #(
         .CX (x),
         .CY (ROW)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .ctrl          (ctrl),
         .left_reached  (left_nb),
         .right_reached (right_nb),
         .up_reached    (up_reached[x]),
         .down_reached  (down_reached[x]),
         .reached       (reached[x]),
         .flags         (cell_flags[x])
      );
   end

   always_comb begin
      row_flags_in = '0;
      for (int i = 0; i < GRID_SIDE; i++) begin
         row_flags_in = row_flags_in | cell_flags[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_flags_ff <= '0;
      end else begin
         row_flags_ff <= row_flags_in;
      end
   end

   assign row_flags = row_flags_ff;

endmodule

`default_nettype wire

>>> dv/tb_grid_reachability_wave.sv
// tb_grid_reachability_wave: self-checking testbench for grid_reachability_wave.
// Depends on grw_pkg and the grid_reachability_wave RTL; holds a small
// scoreboard class with its own occupancy map and flood-fill reachability check.
`default_nettype none

module tb_grid_reachability_wave;
   import grw_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int GRID_SIDE  = 16;
   localparam int GRID_CELLS = GRID_SIDE * GRID_SIDE;
   localparam int REQ_W      = $bits(req_type);
   // Generous ceiling: ~2000 transactions, each at most one full maze-length wave plus
   // sender gaps, receiver stalls and one long hold-off, taken several times.
   localparam longint RUN_LIMIT_NS = 64'd40_000_000;

   // ------------------------------------------------------------------------
   // Scoreboard: mirrors the occupancy map, predicts each result when its
   // request transaction is accepted, and checks results in order.
   // ------------------------------------------------------------------------
   class reach_scoreboard;
      bit      occ [GRID_CELLS];
      rsp_type expected_q [$];
      int      errors;
      int      n_writes;
      int      n_queries;
      int      n_reach;
      int      n_blocked;
      int      n_checked;

      function new();
         foreach (occ[i]) occ[i] = 1'b0;
         errors    = 0;
         n_writes  = 0;
         n_queries = 0;
         n_reach   = 0;
         n_blocked = 0;
         n_checked = 0;
      endfunction

      // Flood fill through empty cells; the source itself may be occupied.
      // Same answer as the synchronous wave, since the wave only stops when
      // the connected region is exhausted.
      function bit flood_reaches(int sx, int sy, int dx, int dy);
         bit seen [GRID_CELLS];
         int frontier [$];
         int here, hx, hy, nx, ny, k;
         foreach (seen[i]) seen[i] = 1'b0;
         seen[sy * GRID_SIDE + sx] = 1'b1;
         frontier.push_back(sy * GRID_SIDE + sx);
         while (frontier.size() != 0) begin
            here = frontier.pop_front();
            if (here == dy * GRID_SIDE + dx) return 1'b1;
            hx = here % GRID_SIDE;
            hy = here / GRID_SIDE;
            for (k = 0; k < 4; k++) begin
               nx = hx + ((k == 0) ? 1 : (k == 1) ? -1 : 0);
               ny = hy + ((k == 2) ? 1 : (k == 3) ? -1 : 0);
               if (nx >= 0 && nx < GRID_SIDE && ny >= 0 && ny < GRID_SIDE) begin
                  if (!seen[ny * GRID_SIDE + nx] && !occ[ny * GRID_SIDE + nx]) begin
                     seen[ny * GRID_SIDE + nx] = 1'b1;
                     frontier.push_back(ny * GRID_SIDE + nx);
                  end
               end
            end
         end
         return 1'b0;
      endfunction

      function rsp_type predict(req_type r);
         rsp_type res;
         int      dst;
         res = '0;
         if (r.func == FUNC_WRITE) begin
            n_writes++;
            // writes off the grid are dropped
            if (int'(r.cell_x) < GRID_SIDE && int'(r.cell_y) < GRID_SIDE)
               occ[int'(r.cell_y) * GRID_SIDE + int'(r.cell_x)] = r.occupied;
         end else begin
            n_queries++;
            if (int'(r.dst_x) < GRID_SIDE && int'(r.dst_y) < GRID_SIDE) begin
               dst = int'(r.dst_y) * GRID_SIDE + int'(r.dst_x);
               if (occ[dst]) begin
                  // occupied target wins, even when it is the source
                  res.target_blocked = 1'b1;
                  n_blocked++;
               end else if (int'(r.src_x) < GRID_SIDE && int'(r.src_y) < GRID_SIDE) begin
                  res.reachable = flood_reaches(int'(r.src_x), int'(r.src_y),
                                                int'(r.dst_x), int'(r.dst_y));
                  if (res.reachable) n_reach++;
               end
            end
         end
         return res;
      endfunction

      function void note_request(req_type r);
         expected_q.push_back(predict(r));
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      task report(string msg);
         $display("MISMATCH @%0t: %s", $realtime, msg);
         errors++;
      endtask

      task check_result(rsp_type got);
         rsp_type want;
         if (expected_q.size() == 0) begin
            report($sformatf("result %0d with nothing outstanding", n_checked));
         end else begin
            want = expected_q.pop_front();
            if (got.reachable !== want.reachable)
               report($sformatf("result %0d reachable got %b want %b",
                                n_checked, got.reachable, want.reachable));
            if (got.target_blocked !== want.target_blocked)
               report($sformatf("result %0d target_blocked got %b want %b",
                                n_checked, got.target_blocked, want.target_blocked));
         end
         n_checked++;
      endtask
   endclass

   // ------------------------------------------------------------------------
   // DUT hookup
   // ------------------------------------------------------------------------
   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   grid_reachability_wave #(
      .GRID_SIDE (GRID_SIDE)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   reach_scoreboard sb = new();

   // Idling knobs, percent of cycles; set by the phase sequencer.
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   // Receiver hold-off request; counted down by the receiver process.
   int hold_left = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Timeout guard.
   initial begin
      #(RUN_LIMIT_NS);
      $display("timeout: %0d results still outstanding", sb.pending());
      $display("tb_grid_reachability_wave: errors");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Result side: check every accepted result transaction, then pick the next
   // cycle's ready. A pending hold-off overrides the random stalls, which is
   // what backs the block up until it stops taking requests.
   // ------------------------------------------------------------------------
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_data);
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Request builders; the fields the operation does not use are random.
   // ------------------------------------------------------------------------
   function automatic req_type make_write(int x, int y, bit o);
      req_type r;
      r          = req_type'(REQ_W'($urandom));
      r.func     = FUNC_WRITE;
      r.cell_x   = COORD_W'(x);
      r.cell_y   = COORD_W'(y);
      r.occupied = o;
      return r;
   endfunction

   function automatic req_type make_query(int sx, int sy, int dx, int dy);
      req_type r;
      r       = req_type'(REQ_W'($urandom));
      r.func  = FUNC_QUERY;
      r.src_x = COORD_W'(sx);
      r.src_y = COORD_W'(sy);
      r.dst_x = COORD_W'(dx);
      r.dst_y = COORD_W'(dy);
      return r;
   endfunction

   // Mostly queries; writes lean toward clearing so the map stays mostly open.
   function automatic req_type random_req();
      req_type r;
      r = req_type'(REQ_W'($urandom));
      if ($urandom_range(99) < 55) begin
         r.func = FUNC_QUERY;
      end else begin
         r.func     = FUNC_WRITE;
         r.occupied = ($urandom_range(99) < 35);
      end
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------
   // One request transaction: optional random idle, then hold valid until
   // accepted. Valid is lowered only when a gap is actually taken.
   task automatic send_req(req_type r);
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      sb.note_request(r);
   endtask

   // Stop offering and wait until every predicted result has been checked.
   // The wait is a do-while, so valid is never lowered and raised in one step.
   task automatic wait_results_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // Serpentine maze: odd rows but the last are walls with one random gap, even rows get
   // sparse obstacles. Corner to corner then needs a wave that winds through every gap.
   task automatic run_maze();
      int gap_x [GRID_SIDE];
      int x, y, k;
      bit blk;
      for (y = 0; y < GRID_SIDE; y++) gap_x[y] = $urandom_range(GRID_SIDE - 1);
      for (y = 0; y < GRID_SIDE; y++) begin
         for (x = 0; x < GRID_SIDE; x++) begin
            if (y % 2 == 1 && y < GRID_SIDE - 1) blk = (x != gap_x[y]);
            else if (y % 2 == 0)                 blk = ($urandom_range(99) < 4);
            else                                 blk = 1'b0;
            send_req(make_write(x, y, blk));
         end
      end
      send_req(make_query(0, 0, GRID_SIDE - 1, GRID_SIDE - 1));
      send_req(make_query(GRID_SIDE - 1, GRID_SIDE - 1, 0, 0));
      for (k = 0; k < 6; k++) begin
         send_req(make_query($urandom_range(GRID_SIDE - 1), $urandom_range(GRID_SIDE - 1),
                             $urandom_range(GRID_SIDE - 1), $urandom_range(GRID_SIDE - 1)));
      end
      // Seal one gap: the wave floods one side and dies out.
      y = 1 + 2 * $urandom_range(GRID_SIDE / 2 - 2);
      send_req(make_write(gap_x[y], y, 1'b1));
      send_req(make_query(0, 0, GRID_SIDE - 1, GRID_SIDE - 1));
      // start on the sealed (occupied) cell itself
      send_req(make_query(gap_x[y], y, 0, 0));
      send_req(make_write(gap_x[y], y, 1'b0));
      send_req(make_query(0, 0, GRID_SIDE - 1, GRID_SIDE - 1));
      // target inside the wall row, normally blocked
      send_req(make_query(0, 0, (gap_x[y] + 1) % GRID_SIDE, y));
   endtask

   task automatic run_random(int count, int hold_at, int drain_at);
      int i;
      for (i = 0; i < count; i++) begin
         // long receiver hold-off while requests keep coming
         if (i == hold_at) hold_left = 450;
         if (i == drain_at) wait_results_drained();
         send_req(random_req());
      end
   endtask

   // Directed corner cases on a fresh map.
   task automatic run_directed();
      send_req(make_query(0, 0, GRID_SIDE - 1, GRID_SIDE - 1));          // open map
      send_req(make_query(GRID_SIDE - 1, 0, 0, GRID_SIDE - 1));
      send_req(make_query(7, 9, 7, 9));                                  // target is source
      send_req(make_write(GRID_SIDE - 1, GRID_SIDE - 1, 1'b1));
      send_req(make_query(0, 0, GRID_SIDE - 1, GRID_SIDE - 1));          // target occupied
      send_req(make_query(GRID_SIDE - 1, GRID_SIDE - 1,
                          GRID_SIDE - 1, GRID_SIDE - 1));                // occupied, same as source
      send_req(make_write(0, 0, 1'b1));
      send_req(make_query(0, 0, GRID_SIDE - 1, GRID_SIDE - 2));          // occupied source still seeds
      send_req(make_write(1, 0, 1'b1));
      send_req(make_write(0, 1, 1'b1));
      send_req(make_query(0, 0, 5, 5));                                  // source boxed in
      send_req(make_write(0, 0, 1'b0));
      send_req(make_query(9, 9, 0, 0));                                  // target boxed in, full flood
      send_req(make_write(1, 0, 1'b0));
      send_req(make_query(9, 9, 0, 0));
      send_req(make_write(GRID_SIDE - 1, GRID_SIDE - 1, 1'b0));
      send_req(make_write(0, 1, 1'b0));
      send_req(make_query(0, GRID_SIDE - 1, GRID_SIDE - 1, 0));
      send_req(make_query(GRID_SIDE - 1, GRID_SIDE - 1, GRID_SIDE - 1, GRID_SIDE - 1));
   endtask

   // ------------------------------------------------------------------------
   // Phase sequencer
   // ------------------------------------------------------------------------
   initial begin
      int phase;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      run_directed();
      wait_results_drained();

      // phases: no idling, sender idle, receiver stalls, both lightly
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 0;  recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 86; recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;  recv_stall_pct = 86;
            end
            default: begin
               send_idle_pct = 13; recv_stall_pct = 13;
            end
         endcase
         run_maze();
         run_random(230, (phase == 0) ? 40 : -1, (phase == 0 || phase == 2) ? 120 : -1);
         wait_results_drained();
      end

      // let any stray result show up
      repeat (200) @(posedge clock);
      if (sb.pending() != 0)
         sb.report($sformatf("%0d results never arrived", sb.pending()));

      $display("summary: %0d writes and %0d queries checked (%0d reachable, %0d target blocked)",
               sb.n_writes, sb.n_queries, sb.n_reach, sb.n_blocked);
      $display("summary: serpentine mazes and random maps under four idle/stall mixes");
      if (sb.errors == 0) begin
         $display("tb_grid_reachability_wave: clean");
      end else begin
         $display("tb_grid_reachability_wave: errors");
      end
      $finish;
   end

endmodule

`default_nettype wire
